// ===== hdl/mpes_pkg.sv =====
// ----------------------------------------------------------------------------
// mpes_pkg
// Shared types and tag codes for the MsgPack element skipper.
// ----------------------------------------------------------------------------
`default_nettype none

package mpes_pkg;

  // pending element counter width (twice a 32-bit map count plus headroom)
  localparam int unsigned PEND_W   = 34;
  localparam int unsigned LENOUT_W = 32;

  typedef enum logic [1:0] {
    PH_TYPE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_SKIP   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_LEN   = 2'd0,
    KIND_ARRAY = 2'd1,
    KIND_MAP   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_UNSUP = 2'd2
  } status_e;

  // type byte ranges
  localparam logic [7:0] POSFIX_MAX   = 8'h7F;
  localparam logic [7:0] NEGFIX_MIN   = 8'hE0;
  localparam logic [7:0] FIXMAP_MIN   = 8'h80;
  localparam logic [7:0] FIXMAP_MAX   = 8'h8F;
  localparam logic [7:0] FIXARR_MIN   = 8'h90;
  localparam logic [7:0] FIXARR_MAX   = 8'h9F;
  localparam logic [7:0] FIXSTR_MIN   = 8'hA0;
  localparam logic [7:0] FIXSTR_MAX   = 8'hBF;
  localparam logic [7:0] FIXSTR_MASK  = 8'h1F;
  localparam logic [7:0] FIXCNT_MASK  = 8'h0F;

  // single type bytes
  localparam logic [7:0] TAG_NIL      = 8'hC0;
  localparam logic [7:0] TAG_FALSE    = 8'hC2;
  localparam logic [7:0] TAG_TRUE     = 8'hC3;
  localparam logic [7:0] TAG_BIN8     = 8'hC4;
  localparam logic [7:0] TAG_BIN16    = 8'hC5;
  localparam logic [7:0] TAG_BIN32    = 8'hC6;
  localparam logic [7:0] TAG_FLOAT32  = 8'hCA;
  localparam logic [7:0] TAG_FLOAT64  = 8'hCB;
  localparam logic [7:0] TAG_UINT8    = 8'hCC;
  localparam logic [7:0] TAG_UINT16   = 8'hCD;
  localparam logic [7:0] TAG_UINT32   = 8'hCE;
  localparam logic [7:0] TAG_UINT64   = 8'hCF;
  localparam logic [7:0] TAG_INT8     = 8'hD0;
  localparam logic [7:0] TAG_INT16    = 8'hD1;
  localparam logic [7:0] TAG_INT32    = 8'hD2;
  localparam logic [7:0] TAG_INT64    = 8'hD3;
  localparam logic [7:0] TAG_STR8     = 8'hD9;
  localparam logic [7:0] TAG_STR16    = 8'hDA;
  localparam logic [7:0] TAG_STR32    = 8'hDB;
  localparam logic [7:0] TAG_ARRAY16  = 8'hDC;
  localparam logic [7:0] TAG_ARRAY32  = 8'hDD;
  localparam logic [7:0] TAG_MAP16    = 8'hDE;
  localparam logic [7:0] TAG_MAP32    = 8'hDF;

  // decoded type byte
  typedef struct packed {
    logic        unsupported;
    logic        start_hdr;    // a length or count field of one or more bytes follows
    logic [2:0]  hdr_bytes;
    kind_e       kind;
    logic        start_skip;   // nonzero payload follows
    logic [4:0]  skip_len;
    logic [4:0]  pending_add;  // elements added by a fix container
  } dec_t;

  // one result item
  typedef struct packed {
    status_e              status;
    logic [LENOUT_W-1:0]  length;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/mpes_if.sv =====
// ----------------------------------------------------------------------------
// mpes_if
// Valid/ready stream channels for the byte input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mpes_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] element_length;

  modport source (output valid, output status, output element_length, input ready);
  modport sink   (input valid, input status, input element_length, output ready);
endinterface

`default_nettype wire

// ===== hdl/mpes_type_decode.sv =====
// ----------------------------------------------------------------------------
// mpes_type_decode
// Classifies a MsgPack type byte: scalar, fix container, header, skip or unsupported.
// ----------------------------------------------------------------------------
`default_nettype none

module mpes_type_decode (
  input  logic [7:0]     type_byte_i,
  output mpes_pkg::dec_t dec_o
);

  always_comb begin
    dec_o             = '0;
    dec_o.kind        = mpes_pkg::KIND_LEN;
    if (type_byte_i <= mpes_pkg::POSFIX_MAX || type_byte_i >= mpes_pkg::NEGFIX_MIN ||
        type_byte_i == mpes_pkg::TAG_NIL || type_byte_i == mpes_pkg::TAG_FALSE ||
        type_byte_i == mpes_pkg::TAG_TRUE) begin
      // complete in one byte
    end else if (type_byte_i >= mpes_pkg::FIXSTR_MIN &&
                 type_byte_i <= mpes_pkg::FIXSTR_MAX) begin
      dec_o.skip_len   = 5'(type_byte_i & mpes_pkg::FIXSTR_MASK);
      dec_o.start_skip = (dec_o.skip_len != 5'd0);
    end else if (type_byte_i >= mpes_pkg::FIXARR_MIN &&
                 type_byte_i <= mpes_pkg::FIXARR_MAX) begin
      dec_o.pending_add = 5'(type_byte_i & mpes_pkg::FIXCNT_MASK);
    end else if (type_byte_i >= mpes_pkg::FIXMAP_MIN &&
                 type_byte_i <= mpes_pkg::FIXMAP_MAX) begin
      dec_o.pending_add = {type_byte_i[3:0], 1'b0};
    end else begin
      case (type_byte_i)
        mpes_pkg::TAG_BIN8, mpes_pkg::TAG_STR8: begin
          dec_o.start_hdr = 1'b1;
          dec_o.hdr_bytes = 3'd1;
        end
        mpes_pkg::TAG_BIN16, mpes_pkg::TAG_STR16: begin
          dec_o.start_hdr = 1'b1;
          dec_o.hdr_bytes = 3'd2;
        end
        mpes_pkg::TAG_BIN32, mpes_pkg::TAG_STR32: begin
          dec_o.start_hdr = 1'b1;
          dec_o.hdr_bytes = 3'd4;
        end
        mpes_pkg::TAG_UINT8, mpes_pkg::TAG_INT8: begin
          dec_o.start_skip = 1'b1;
          dec_o.skip_len   = 5'd1;
        end
        mpes_pkg::TAG_UINT16, mpes_pkg::TAG_INT16: begin
          dec_o.start_skip = 1'b1;
          dec_o.skip_len   = 5'd2;
        end
        mpes_pkg::TAG_FLOAT32, mpes_pkg::TAG_UINT32, mpes_pkg::TAG_INT32: begin
          dec_o.start_skip = 1'b1;
          dec_o.skip_len   = 5'd4;
        end
        mpes_pkg::TAG_FLOAT64, mpes_pkg::TAG_UINT64, mpes_pkg::TAG_INT64: begin
          dec_o.start_skip = 1'b1;
          dec_o.skip_len   = 5'd8;
        end
        mpes_pkg::TAG_ARRAY16: begin
          dec_o.start_hdr = 1'b1;
          dec_o.hdr_bytes = 3'd2;
          dec_o.kind      = mpes_pkg::KIND_ARRAY;
        end
        mpes_pkg::TAG_ARRAY32: begin
          dec_o.start_hdr = 1'b1;
          dec_o.hdr_bytes = 3'd4;
          dec_o.kind      = mpes_pkg::KIND_ARRAY;
        end
        mpes_pkg::TAG_MAP16: begin
          dec_o.start_hdr = 1'b1;
          dec_o.hdr_bytes = 3'd2;
          dec_o.kind      = mpes_pkg::KIND_MAP;
        end
        mpes_pkg::TAG_MAP32: begin
          dec_o.start_hdr = 1'b1;
          dec_o.hdr_bytes = 3'd4;
          dec_o.kind      = mpes_pkg::KIND_MAP;
        end
        default: begin
          dec_o.unsupported = 1'b1;  // ext types and the reserved byte
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mpes_walker.sv =====
// ----------------------------------------------------------------------------
// mpes_walker
// Parse state registers and per-byte next-state logic of the skipper.
// ----------------------------------------------------------------------------
`default_nettype none

module mpes_walker #(
  parameter int unsigned LEN_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  output logic           emit_o,
  output mpes_pkg::res_t res_o
);

  localparam int unsigned PW = mpes_pkg::PEND_W;

  mpes_pkg::phase_e phase_q, phase_d;
  mpes_pkg::kind_e  kind_q, kind_d;
  logic [PW-1:0]       pend_q, pend_d;
  logic [2:0]          hleft_q, hleft_d;
  logic [31:0]         asm_q, asm_d;
  logic [31:0]         skip_q, skip_d;
  logic [LEN_BITS-1:0] cnt_q, cnt_d;

  mpes_pkg::dec_t dec;

  logic [LEN_BITS-1:0] cnt_inc;
  logic [PW-1:0]       pend_dec, pend_base, add_val, pend_sum;
  logic [PW:0]         pend_wide;
  logic [31:0]         asm_next, skip_dec;
  logic [2:0]          hleft_dec;
  logic                ended;

  mpes_type_decode u_dec (
    .type_byte_i (data_byte_i),
    .dec_o       (dec)
  );

  assign cnt_inc   = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
  assign pend_dec  = (pend_q != '0) ? pend_q - 1'b1 : pend_q;
  assign asm_next  = {asm_q[23:0], data_byte_i};
  assign hleft_dec = (hleft_q != 3'd0) ? hleft_q - 3'd1 : hleft_q;
  assign skip_dec  = (skip_q != 32'd0) ? skip_q - 32'd1 : skip_q;

  // one saturating add serves both fix containers and count headers
  always_comb begin
    pend_base = (phase_q == mpes_pkg::PH_TYPE) ? pend_dec : pend_q;
    add_val   = '0;
    if (phase_q == mpes_pkg::PH_TYPE) begin
      add_val = PW'(dec.pending_add);
    end else if (phase_q == mpes_pkg::PH_HEADER) begin
      case (kind_q)
        mpes_pkg::KIND_ARRAY: add_val = PW'(asm_next);
        mpes_pkg::KIND_MAP:   add_val = PW'({asm_next, 1'b0});
        default:              add_val = '0;
      endcase
    end
    pend_wide = {1'b0, pend_base} + {1'b0, add_val};
    pend_sum  = pend_wide[PW] ? '1 : pend_wide[PW-1:0];
  end

  always_comb begin
    phase_d    = phase_q;
    kind_d     = kind_q;
    pend_d     = pend_q;
    hleft_d    = hleft_q;
    asm_d      = asm_q;
    skip_d     = skip_q;
    cnt_d      = cnt_inc;
    ended      = 1'b0;
    emit_o     = 1'b0;
    res_o.status = mpes_pkg::ST_OK;
    res_o.length = mpes_pkg::LENOUT_W'(cnt_inc);

    case (phase_q)
      mpes_pkg::PH_TYPE: begin
        pend_d = pend_sum;
        if (dec.unsupported) begin
          emit_o       = 1'b1;
          res_o.status = mpes_pkg::ST_UNSUP;
        end else if (dec.start_hdr) begin
          phase_d = mpes_pkg::PH_HEADER;
          hleft_d = dec.hdr_bytes;
          kind_d  = dec.kind;
          asm_d   = '0;
        end else if (dec.start_skip) begin
          phase_d = mpes_pkg::PH_SKIP;
          skip_d  = 32'(dec.skip_len);
        end else begin
          ended = 1'b1;
        end
      end
      mpes_pkg::PH_HEADER: begin
        asm_d   = asm_next;
        hleft_d = hleft_dec;
        if (hleft_dec == 3'd0) begin
          if (kind_q == mpes_pkg::KIND_ARRAY || kind_q == mpes_pkg::KIND_MAP) begin
            pend_d = pend_sum;
            ended  = 1'b1;
          end else if (asm_next == 32'd0) begin
            ended = 1'b1;
          end else begin
            phase_d = mpes_pkg::PH_SKIP;
            skip_d  = asm_next;
          end
        end
      end
      mpes_pkg::PH_SKIP: begin
        skip_d = skip_dec;
        ended  = (skip_dec == 32'd0);
      end
      default: begin
        cnt_d = cnt_q;  // trailing bytes are not counted
      end
    endcase

    if (phase_q != mpes_pkg::PH_DONE) begin
      if (ended) begin
        if (pend_d == '0) begin
          emit_o       = 1'b1;
          res_o.status = mpes_pkg::ST_OK;
        end else begin
          phase_d = mpes_pkg::PH_TYPE;
        end
      end
      if (!emit_o && last_byte_i) begin
        emit_o       = 1'b1;
        res_o.status = mpes_pkg::ST_TRUNC;
      end
      if (emit_o) begin
        phase_d = mpes_pkg::PH_DONE;
      end
    end

    // the last byte of a buffer always readies the walker for the next one
    if (last_byte_i) begin
      phase_d = mpes_pkg::PH_TYPE;
      kind_d  = mpes_pkg::KIND_LEN;
      pend_d  = PW'(1);
      hleft_d = '0;
      asm_d   = '0;
      skip_d  = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mpes_pkg::PH_TYPE;
      kind_q  <= mpes_pkg::KIND_LEN;
      pend_q  <= PW'(1);
      hleft_q <= '0;
      asm_q   <= '0;
      skip_q  <= '0;
      cnt_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      pend_q  <= pend_d;
      hleft_q <= hleft_d;
      asm_q   <= asm_d;
      skip_q  <= skip_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/msgpack_element_skipper_core.sv =====
// ----------------------------------------------------------------------------
// msgpack_element_skipper_core
// Streaming skipper of one MsgPack element, one byte per clock unless a waiting result holds off the input.
// ----------------------------------------------------------------------------
// Result: a result is registered and appears on the output in the cycle after the byte that ends it.
// Throughput: one byte per cycle while no result waits or the sink is ready; the walker state and
//   the result register are updated in the same cycle, so bytes stream back to back.
// Reset: rst_ni clears the walker to expect a type byte with one pending
//   element, and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module msgpack_element_skipper_core #(
  parameter int unsigned LEN_BITS = 32  // width of the byte counter, 16..32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mpes_in_if.sink           inp_i,
  mpes_out_if.source        res_o
);

  // A byte transfer is taken whenever the result register is empty or is
  // being drained in this same cycle, so a waiting result never stalls the
  // stream unless the sink itself holds off.
  logic           accept;
  logic           emit;
  mpes_pkg::res_t res_d;
  mpes_pkg::res_t res_q;
  logic           res_valid_q, res_valid_d;

  assign inp_i.ready = !res_valid_q || res_o.ready;
  assign accept      = inp_i.valid && inp_i.ready;

  // Walker: type decode, header assembly, payload skip and the pending
  // element count, all resolved for the accepted byte in one pass.
  mpes_walker #(
    .LEN_BITS (LEN_BITS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (inp_i.data_byte),
    .last_byte_i (inp_i.last_byte),
    .emit_o      (emit),
    .res_o       (res_d)
  );

  // Result register: loads on a byte that produces a result, clears when
  // the sink takes the transfer.
  always_comb begin
    if (accept && emit) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.status         = res_q.status;
  assign res_o.element_length = res_q.length;

endmodule

`default_nettype wire
